### rtl/core/kdlp_pkg.sv
// Package for the key debounce block: command codes, configuration register
// indexes, register widths and reset values. No dependencies.
package kdlp_pkg;

  // Command field of an input item.
  localparam int  CMD_W    = 1;
  localparam logic [CMD_W-1:0] CMD_SCAN = 1'b0;
  localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_EN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 2'd2;

  // Hold counter and its reset values.
  localparam int HOLD_W = 8;
  localparam logic [HOLD_W-1:0] LONG_DELAY_RST = 8'd50;
  localparam logic [HOLD_W-1:0] REPEAT_RST     = 8'd10;

  typedef logic [HOLD_W-1:0] hold_t;

endpackage

### rtl/core/kdlp_in_if.sv
// Input channel of the key debounce block: valid/ready plus command and raw keys.
// Depends on kdlp_pkg.
interface kdlp_in_if import kdlp_pkg::*; #(
  parameter int KEY_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [KEY_BITS-1:0] raw_keys;

  modport source (output valid, output command, output raw_keys, input ready);
  modport sink   (input valid, input command, input raw_keys, output ready);
endinterface

### rtl/core/kdlp_out_if.sv
// Result channel of the key debounce block: valid/ready plus the event fields.
// Depends on nothing but its parameters.
interface kdlp_out_if #(
  parameter int KEY_BITS = 16,
  parameter int CNT_W    = 4
);
  logic                valid;
  logic                ready;
  logic                event_valid;
  logic [KEY_BITS-1:0] event_keys;
  logic                event_long;
  logic [KEY_BITS-1:0] debounced_keys;
  logic [CNT_W-1:0]    queued_count;

  modport source (output valid, output event_valid, output event_keys, output event_long,
                  output debounced_keys, output queued_count, input ready);
  modport sink   (input valid, input event_valid, input event_keys, input event_long,
                  input debounced_keys, input queued_count, output ready);
endinterface

### rtl/core/kdlp_cfg_if.sv
// Configuration write channel of the key debounce block: valid/ready, index, data.
// Depends on kdlp_pkg.
interface kdlp_cfg_if import kdlp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/key_debounce_long_press_fifo_top.sv
// Top level of the key debounce block with long-press detection and event queue.
// Depends on kdlp_pkg, kdlp_in_if, kdlp_out_if and kdlp_cfg_if.
//
// Usage:
//   in_ch carries one item per handshake: a scan (raw key bitmap) or a pop.
//   out_ch returns exactly one result item per input item, in order. A scan
//   result carries the filtered keys and queue fill with no event; a pop result
//   carries the oldest queued event, or no event when the queue is empty.
//   cfg_ch writes long-press enable, delay and repeat period; it is always
//   ready and should only be used while no item is in flight.
// Timing and throughput:
//   A result appears in the cycle after its item is accepted. One item is taken
//   every cycle unless a result waits for the receiver; the whole update is one
//   pass of logic from the state and input into the state and result registers.
// Stall behavior:
//   The result register is a single stage. While it holds an item that the
//   receiver has not taken, the input is not ready; a new item is taken in the
//   same cycle that the waiting result leaves, so no cycle is lost.
// Reset:
//   rst_n low clears the filter, mask, queue pointers and count, loads the
//   hold counter with the default delay and restores default configuration.
//   The event store is not cleared; only written entries are ever read.
module key_debounce_long_press_fifo_top import kdlp_pkg::*; #(
  parameter int KEY_BITS    = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  kdlp_in_if.sink           in_ch,
  kdlp_out_if.source        out_ch,
  kdlp_cfg_if.sink          cfg_ch
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_W = KEY_BITS + 1;
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  // Configuration registers.
  logic  long_en_r;
  hold_t long_delay_r;
  hold_t repeat_r;

  // Filter, hold and queue control state.
  logic [KEY_BITS-1:0] last_raw_r,  last_raw_nxt;
  logic [KEY_BITS-1:0] filt_r,      filt_nxt;
  logic [KEY_BITS-1:0] mask_r,      mask_nxt;
  hold_t               hold_r,      hold_nxt;
  logic [PTR_W-1:0]    wp_r,        wp_nxt;
  logic [PTR_W-1:0]    rp_r,        rp_nxt;
  logic [CNT_W-1:0]    cnt_r,       cnt_nxt;

  // Event store: keys in the low bits, long-press flag on top.
  logic [WORD_W-1:0]   store_mem [QUEUE_DEPTH];

  // Result register.
  logic                out_valid_r;
  logic                ev_valid_r;
  logic [WORD_W-1:0]   ev_word_r;

  logic                accept;
  logic                is_pop;
  logic                pop_ok;
  logic [KEY_BITS-1:0] cur;
  logic [KEY_BITS-1:0] released;
  logic                held;
  hold_t               hold_dec;
  logic                long_push;
  logic                short_push;
  logic                push;
  logic [WORD_W-1:0]   push_word;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_pop      = (in_ch.command == CMD_POP);
  assign pop_ok      = is_pop && (cnt_r != '0);

  // A key follows the raw input once two samples in a row agree.
  assign cur      = (last_raw_r & in_ch.raw_keys) | (filt_r & (last_raw_r ^ in_ch.raw_keys));
  assign released = filt_r & ~cur;
  assign held     = long_en_r && (cur == filt_r) && (cur != '0);
  assign hold_dec = hold_r - hold_t'(1);

  // A long press needs an unchanged bitmap, so it never coincides with a release.
  assign long_push  = !is_pop && held && (hold_dec == '0);
  assign short_push = !is_pop && (released != '0) && ((released & ~mask_r) != '0);
  assign push       = long_push || short_push;
  assign push_word  = long_push ? {1'b1, cur} : {1'b0, released};

  always_comb begin
    last_raw_nxt = last_raw_r;
    filt_nxt     = filt_r;
    mask_nxt     = mask_r;
    hold_nxt     = hold_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    cnt_nxt      = cnt_r;
    if (is_pop) begin
      if (pop_ok) begin
        rp_nxt  = ring_next(rp_r);
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end else begin
      last_raw_nxt = in_ch.raw_keys;
      filt_nxt     = cur;
      if (held) begin
        hold_nxt = long_push ? repeat_r : hold_dec;
      end else begin
        hold_nxt = long_delay_r;
      end
      if (long_push) begin
        mask_nxt = cur;
      end else if ((released != '0) && !short_push) begin
        // Every released key was part of a long press: drop the mask.
        mask_nxt = '0;
      end
      if (push) begin
        wp_nxt = ring_next(wp_r);
        if (cnt_r == FULL_CNT) begin
          // Queue full: the oldest event is overwritten.
          rp_nxt = ring_next(rp_r);
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Configuration writes; out-of-range indexes are ignored.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_en_r    <= 1'b1;
      long_delay_r <= LONG_DELAY_RST;
      repeat_r     <= REPEAT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_LONG_EN:    long_en_r    <= cfg_ch.data[0];
        CFG_LONG_DELAY: long_delay_r <= cfg_ch.data;
        CFG_REPEAT:     repeat_r     <= cfg_ch.data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r  <= '0;
      filt_r      <= '0;
      mask_r      <= '0;
      hold_r      <= LONG_DELAY_RST;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      ev_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        last_raw_r  <= last_raw_nxt;
        filt_r      <= filt_nxt;
        mask_r      <= mask_nxt;
        hold_r      <= hold_nxt;
        wp_r        <= wp_nxt;
        rp_r        <= rp_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
        ev_valid_r  <= pop_ok;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Event store: a scan may write one entry, a pop reads one; never both.
  always_ff @(posedge clk) begin
    if (accept && push) begin
      store_mem[wp_r] <= push_word;
    end
    if (accept && pop_ok) begin
      ev_word_r <= store_mem[rp_r];
    end
  end

  // Only one item is ever in flight past the input, so the filtered keys and
  // queue fill in the state registers belong to the item in the result register.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_valid    = ev_valid_r;
  assign out_ch.event_keys     = ev_valid_r ? ev_word_r[KEY_BITS-1:0] : '0;
  assign out_ch.event_long     = ev_valid_r && ev_word_r[KEY_BITS];
  assign out_ch.debounced_keys = filt_r;
  assign out_ch.queued_count   = cnt_r;

endmodule

### sim/key_debounce_long_press_fifo_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for key_debounce_long_press_fifo_top: scan and pop items
// are checked against a scoreboard that predicts the filter, long-press and queue.
// Depends on kdlp_pkg, the three channel interfaces and the top-level RTL.
module key_debounce_long_press_fifo_top_tb import kdlp_pkg::*;;

  localparam int KEY_BITS        = 16;
  localparam int QUEUE_DEPTH     = 8;
  localparam int CNT_W           = 4;
  localparam int HOLD_OFF_CYCLES = 80;

  // The configuration index field has one code with no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One result item as the block presents it.
  typedef struct packed {
    logic                evt_valid;
    logic [KEY_BITS-1:0] evt_keys;
    logic                evt_long;
    logic [KEY_BITS-1:0] debounced;
    logic [CNT_W-1:0]    queued;
  } key_result_t;

  // The scoreboard carries its own copy of the filter, the hold counter, the release
  // mask and the event ring. Every accepted item is run through it at once and its
  // predicted result waits in a queue until the block returns the matching result.
  class key_event_scoreboard;
    bit                  long_en;
    hold_t               long_delay;
    hold_t               repeat_len;
    logic [KEY_BITS-1:0] prev_raw;
    logic [KEY_BITS-1:0] filtered;
    logic [KEY_BITS-1:0] held_mask;
    hold_t               hold_cnt;
    logic [KEY_BITS:0]   ring [QUEUE_DEPTH];
    int                  wr_ptr;
    int                  rd_ptr;
    int                  fill;
    key_result_t         pending_results[$];
    int mismatches, scans, pops_hit, pops_empty, long_events, short_events, drops;

    function new();
      long_en    = 1'b1;
      long_delay = LONG_DELAY_RST;
      repeat_len = REPEAT_RST;
      prev_raw   = '0;
      filtered   = '0;
      held_mask  = '0;
      hold_cnt   = LONG_DELAY_RST;
      wr_ptr     = 0;
      rd_ptr     = 0;
      fill       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_LONG_EN:    long_en    = value[0];
        CFG_LONG_DELAY: long_delay = value;
        CFG_REPEAT:     repeat_len = value;
        default: ;
      endcase
    endfunction

    function int next_slot(int p);
      return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
    endfunction

    // A push into a full ring throws away the oldest event.
    function void queue_event(logic is_long, logic [KEY_BITS-1:0] keys);
      if (fill == QUEUE_DEPTH) begin
        rd_ptr = next_slot(rd_ptr);
        fill--;
        drops++;
      end
      ring[wr_ptr] = {is_long, keys};
      wr_ptr = next_slot(wr_ptr);
      fill++;
      if (is_long) long_events++;
      else short_events++;
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, logic [KEY_BITS-1:0] raw);
      key_result_t         r;
      logic [KEY_BITS-1:0] cur;
      logic [KEY_BITS-1:0] released;
      r = '0;
      if (cmd == CMD_POP) begin
        if (fill > 0) begin
          r.evt_valid = 1'b1;
          {r.evt_long, r.evt_keys} = ring[rd_ptr];
          rd_ptr = next_slot(rd_ptr);
          fill--;
          pops_hit++;
        end else begin
          pops_empty++;
        end
      end else begin
        scans++;
        // A bit follows the raw input only when two samples in a row agree.
        cur      = (prev_raw & raw) | (filtered & (prev_raw ^ raw));
        released = filtered & ~cur;
        if (long_en && cur == filtered && cur != '0) begin
          hold_cnt = hold_cnt - hold_t'(1);
          if (hold_cnt == '0) begin
            queue_event(1'b1, cur);
            hold_cnt  = repeat_len;
            held_mask = cur;
          end
        end else begin
          hold_cnt = long_delay;
        end
        if (released != '0) begin
          if ((released & ~held_mask) != '0) queue_event(1'b0, released);
          else held_mask = '0;
        end
        prev_raw = raw;
        filtered = cur;
      end
      r.debounced = filtered;
      r.queued    = CNT_W'(fill);
      pending_results.push_back(r);
    endfunction

    function void log_mismatch(string what, logic [KEY_BITS-1:0] want,
                               logic [KEY_BITS-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_result(key_result_t got);
      key_result_t want;
      if (pending_results.size() == 0) begin
        log_mismatch("unrequested result, debounced_keys", '0, got.debounced);
        return;
      end
      want = pending_results.pop_front();
      if (got.evt_valid !== want.evt_valid)
        log_mismatch("event_valid", KEY_BITS'(want.evt_valid), KEY_BITS'(got.evt_valid));
      if (got.evt_keys !== want.evt_keys)
        log_mismatch("event_keys", want.evt_keys, got.evt_keys);
      if (got.evt_long !== want.evt_long)
        log_mismatch("event_long", KEY_BITS'(want.evt_long), KEY_BITS'(got.evt_long));
      if (got.debounced !== want.debounced)
        log_mismatch("debounced_keys", want.debounced, got.debounced);
      if (got.queued !== want.queued)
        log_mismatch("queued_count", KEY_BITS'(want.queued), KEY_BITS'(got.queued));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  kdlp_in_if  #(.KEY_BITS(KEY_BITS))                in_ch ();
  kdlp_out_if #(.KEY_BITS(KEY_BITS), .CNT_W(CNT_W)) out_ch ();
  kdlp_cfg_if                                       cfg_ch ();

  key_debounce_long_press_fifo_top #(
    .KEY_BITS    (KEY_BITS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  key_event_scoreboard event_book;

  // Shared knobs between the stimulus and the two idling processes.
  bit idle_allowed = 1'b1;
  bit hold_off_req = 1'b0;
  int tx_calm      = 0;
  int items_sent   = 0;
  int cur_delay    = LONG_DELAY_RST;
  int cur_repeat   = REPEAT_RST;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up on a hung run. The slowest legal run is well under a tenth of this.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Monitor. All three channels are sampled at the rising edge, where the values
  // seen are the ones from before the edge's own updates. The result is checked
  // before the same edge's new item is noted, because a result always belongs to
  // an item accepted at an earlier edge.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_ch.valid && out_ch.ready)
        event_book.check_result(key_result_t'{out_ch.event_valid, out_ch.event_keys,
                                              out_ch.event_long, out_ch.debounced_keys,
                                              out_ch.queued_count});
      if (in_ch.valid && in_ch.ready)
        event_book.note_item(in_ch.command, in_ch.raw_keys);
      if (cfg_ch.valid && cfg_ch.ready)
        event_book.write_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  // Receiver. It stalls in random bursts, sometimes stays ready for a while, and
  // once holds off for a long stretch so that the result stage fills up and the
  // block has to push back on its input.
  initial begin
    int calm_left;
    calm_left = 0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (idle_allowed && calm_left == 0 && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(20, 80);
      end else begin
        out_ch.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
        @(posedge clk);
      end
    end
  end

  // Offer one item and return at the edge where it is taken. The valid stays high
  // afterwards, so the next call either replaces the payload in the same step or
  // lowers valid for a gap; the caller lowers it with stop_sending otherwise.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_BITS-1:0] keys);
    if (idle_allowed) begin
      if (tx_calm > 0) begin
        tx_calm--;
      end else if ($urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        if ($urandom_range(0, 7) == 0) tx_calm = $urandom_range(20, 80);
      end
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.raw_keys <= keys;
    items_sent++;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic scan_keys(input logic [KEY_BITS-1:0] keys);
    send_item(CMD_SCAN, keys);
  endtask

  // The raw key field is ignored on a pop, so it carries noise.
  task automatic pop_event();
    send_item(CMD_POP, KEY_BITS'($urandom));
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  // Wait until every item has its result back. The block registers a result in the
  // cycle after accepting its item, so the extra wait after that leaves it fully idle.
  task automatic wait_drained();
    do @(posedge clk); while (event_book.pending_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value, input bit last_one);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    if (last_one) cfg_ch.valid <= 1'b0;
  endtask

  // Writes all three registers back to back, optionally followed by a write to
  // the index that has no register, which must leave everything unchanged.
  task automatic configure(input bit en, input int delay, input int rep, input bit poke_unused);
    set_register(CFG_LONG_EN, CFG_DATA_W'(en), 1'b0);
    set_register(CFG_LONG_DELAY, CFG_DATA_W'(delay), 1'b0);
    set_register(CFG_REPEAT, CFG_DATA_W'(rep), !poke_unused);
    if (poke_unused) set_register(CFG_UNUSED, CFG_DATA_W'($urandom), 1'b1);
    cur_delay  = (delay == 0) ? 256 : delay;
    cur_repeat = (rep == 0) ? 256 : rep;
  endtask

  function automatic logic [KEY_BITS-1:0] pick_keys();
    case ($urandom_range(0, 5))
      0:       return KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1);
      1:       return '1;
      2:       return {1'b1, {(KEY_BITS-2){1'b0}}, 1'b1};
      default: return KEY_BITS'($urandom_range(1, (1 << KEY_BITS) - 1));
    endcase
  endfunction

  // A press: the keys are held for a number of scans with the odd bounce and pops
  // mixed in, then released either at once or in two steps.
  task automatic press_gesture(input int hold_len, input int pop_pct);
    logic [KEY_BITS-1:0] keys;
    logic [KEY_BITS-1:0] partial;
    keys = pick_keys();
    for (int i = 0; i < hold_len; i++) begin
      if ($urandom_range(0, 99) < pop_pct) pop_event();
      if ($urandom_range(0, 19) == 0) scan_keys(keys ^ KEY_BITS'($urandom));
      scan_keys(keys);
    end
    if ($urandom_range(0, 1) == 1) begin
      partial = keys & KEY_BITS'($urandom);
      repeat (2) scan_keys(partial);
    end
    repeat ($urandom_range(2, 3)) scan_keys('0);
    repeat ($urandom_range(0, 3)) pop_event();
  endtask

  // Hold lengths reach past the first long press and a few repeats, capped so
  // that slow settings do not swallow the item budget.
  function automatic int choose_hold();
    int limit;
    limit = cur_delay + 3 * cur_repeat + 4;
    if (limit > 40) limit = 40;
    return $urandom_range(1, limit);
  endfunction

  // One phase: drain, reprogram, optionally one press long enough to reach the
  // slowest long press and its first repeat, then random presses and a little
  // noise until the phase has offered its share of items.
  task automatic run_phase(input bit en, input int delay, input int rep, input int target,
                           input bit with_long_hold, input bit with_hold_off,
                           input bit poke_unused);
    int start;
    stop_sending();
    wait_drained();
    configure(en, delay, rep, poke_unused);
    start = items_sent;
    if (with_hold_off) hold_off_req = 1'b1;
    if (with_long_hold) press_gesture(cur_delay + cur_repeat + 6, 5);
    while (items_sent - start < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat (5) begin
          if ($urandom_range(0, 9) < 3) pop_event();
          else scan_keys(KEY_BITS'($urandom));
        end
      end else begin
        press_gesture(choose_hold(), $urandom_range(0, 50));
      end
    end
  endtask

  initial begin
    event_book = new();
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_SCAN;
    in_ch.raw_keys <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CFG_LONG_EN;
    cfg_ch.data    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with reset settings: a pop on the empty queue, all keys
    // pressed, one disagreeing sample that must not move the filter, then the
    // release that queues a short press, and two pops.
    pop_event();
    scan_keys('1);
    scan_keys('1);
    scan_keys('0);
    scan_keys('0);
    pop_event();
    pop_event();

    // Short delay and a repeat of one: a held bitmap gives a long press and then
    // one per scan, overflowing the queue. Releasing only masked keys clears the
    // mask without an event; the next release is then a short press again.
    stop_sending();
    wait_drained();
    configure(1'b1, 2, 1, 1'b0);
    repeat (12) scan_keys(16'h00F0);
    repeat (2) scan_keys(16'h0070);
    repeat (2) scan_keys(16'h0000);
    repeat (3) pop_event();

    // Random phases over a spread of settings, extremes included. Delay and
    // period of zero wrap the counter, so those phases need 256 held scans.
    run_phase(1'b1, 1, 1, 130, 1'b0, 1'b0, 1'b0);
    run_phase(1'b1, 5, 3, 130, 1'b0, 1'b1, 1'b0);
    run_phase(1'b0, 7, 2, 100, 1'b0, 1'b0, 1'b0);
    run_phase(1'b1, 255, 1, 270, 1'b1, 1'b0, 1'b0);
    run_phase(1'b1, 1, 255, 270, 1'b1, 1'b0, 1'b0);
    run_phase(1'b1, 0, 0, 560, 1'b1, 1'b0, 1'b0);

    // Closing phase at full rate on both sides.
    idle_allowed = 1'b0;
    run_phase(1'b1, $urandom_range(2, 12), $urandom_range(1, 6), 120, 1'b0, 1'b0, 1'b1);

    stop_sending();
    wait_drained();
    repeat (4) @(posedge clk);

    $display("Run offered %0d items: %0d scans, %0d pops with an event, %0d on an empty queue.",
             items_sent, event_book.scans, event_book.pops_hit, event_book.pops_empty);
    $display("Queued %0d long and %0d short presses, %0d lost to overflow; %0d mismatches.",
             event_book.long_events, event_book.short_events, event_book.drops,
             event_book.mismatches);
    if (event_book.mismatches == 0 && event_book.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
